// File: design/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic signed [31:0] NO_VALUE = -32'sd1;

    typedef struct packed {
        req_t               req_type;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        status_t            status;
        logic [4:0]         occupancy;
    } out_item_t;

    typedef struct packed {
        logic               shift_in;
        logic               shift_out;
        logic               load_back;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// File: design/dq_cell.sv
// One storage cell of the queue chain; front of the queue sits at cell 0.
module dq_cell
    import dq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 5
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [CW-1:0]      count,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    output logic signed [31:0] data,
    output logic signed [31:0] tap
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               is_back;
    logic               is_slot;

    assign is_slot = (count == CW'(INDEX));
    assign is_back = (count == CW'(INDEX + 1));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_in)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_out)
        begin
            data_next = right_data;
        end
        else if (ctrl.load_back && is_slot)
        begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = is_back ? data_reg : '0;

endmodule

// File: design/double_ended_queue.sv
// Top level of the double-ended queue: request decode, entry count and cell chain.
//
//  channel   ports                     handshake
//  request   request (in_item_t)       start && !busy
//  result    result (out_item_t)       done, one cycle, no stall
//
//  One request per cycle; busy stays low. The result is registered and appears
//  in the cycle after acceptance. Front pushes and front pops shift the whole
//  cell chain; a back push loads the cell just past the back of the queue and a
//  back pop takes the cell marked as the back of the queue.
//  Reset clears the entry count and the result strobe; cell contents are
//  undefined until written. The receiver cannot stall the result.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      done,
    output out_item_t result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    logic               done_next;
    out_item_t          result_reg;
    out_item_t          result_next;
    cell_ctrl_t         ctrl;
    logic               accept;
    logic               full;
    logic               empty;
    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] cell_tap  [DEPTH];
    logic signed [31:0] back_value;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | cell_tap[i];
        end
    end

    always_comb
    begin
        ctrl        = '0;
        ctrl.value  = request.push_value;
        count_next  = count_reg;
        done_next   = accept;
        result_next = result_reg;
        if (accept)
        begin
            result_next.pop_value = NO_VALUE;
            result_next.status    = ST_DONE;
            case (request.req_type)
                REQ_PUSH_BACK,
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_in  = (request.req_type == REQ_PUSH_FRONT);
                        ctrl.load_back = (request.req_type == REQ_PUSH_BACK);
                        count_next     = count_reg + CW'(1);
                    end
                end
                REQ_POP_FRONT,
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.shift_out = (request.req_type == REQ_POP_FRONT);
                        result_next.pop_value =
                            (request.req_type == REQ_POP_FRONT) ? cell_data[0] : back_value;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    result_next.status = ST_DONE;
                end
            endcase
            result_next.occupancy = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;
        if (g == 0)
        begin : g_first
            assign left_in = request.push_value;
        end
        else
        begin : g_mid
            assign left_in = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[g];
        end
        else
        begin : g_inner
            assign right_in = cell_data[g+1];
        end
        dq_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g]),
            .tap        (cell_tap[g])
        );
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item gave no result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status with entries held");
`endif

endmodule
